@@ rtl/ecr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecr_pkg: shared constants for the elastic disc collision block
// Default word width and the result status codes.
// ----------------------------------------------------------------------------
package ecr_pkg;

    localparam int ECR_DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_COINCIDENT = 2'd1,
        ST_ZERO_MASS  = 2'd2
    } ecr_status_t;

endpackage

@@ rtl/ecr_delay.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecr_delay: enabled shift line
// Carries side-band values alongside the arithmetic pipeline.
// ----------------------------------------------------------------------------
module ecr_delay
    import ecr_pkg::*;
#(
    parameter int WIDTH = ECR_DATA_WIDTH,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

@@ rtl/ecr_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecr_mul: two-stage unsigned multiplier
// B is cut into slices of at most a word plus one bit; partial products are
// registered, then summed.
// ----------------------------------------------------------------------------
module ecr_mul
    import ecr_pkg::*;
#(
    parameter int AW = ECR_DATA_WIDTH,
    parameter int BW = ECR_DATA_WIDTH
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int SMAX = ECR_DATA_WIDTH + 1;
    localparam int NS0  = (BW + SMAX - 1) / SMAX;
    localparam int NS   = (NS0 < 2) ? 2 : NS0;
    localparam int SL   = (BW + NS - 1) / NS;
    localparam int PW   = AW + BW;

    logic [NS*SL-1:0] b_ext;
    logic [AW+SL-1:0] pp_reg [NS];
    logic [PW-1:0]    p_reg;
    logic [PW-1:0]    p_next;

    assign b_ext = (NS*SL)'(b);

    always_comb begin
        p_next = '0;
        for (int i = 0; i < NS; i++) begin
            p_next = p_next + (PW'(pp_reg[i]) << (i*SL));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NS; i++) begin
                pp_reg[i] <= (AW+SL)'(a) * (AW+SL)'(b_ext[i*SL +: SL]);
            end
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

@@ rtl/ecr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecr_div: pipelined restoring divider, one quotient bit per stage
// Top quotient bit flags a quotient too large for the lower bits.
// ----------------------------------------------------------------------------
module ecr_div
    import ecr_pkg::*;
#(
    parameter int NW   = 4*ECR_DATA_WIDTH + 4,
    parameter int DENW = 3*ECR_DATA_WIDTH + 3,
    parameter int QW   = ECR_DATA_WIDTH + 1
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [NW-1:0]   num,
    input  logic [DENW-1:0] den,
    output logic [QW:0]     q
);

    localparam int CW = (NW > DENW + QW) ? NW : DENW + QW;

    logic [NW-1:0]   rem_reg [QW+1];
    logic [DENW-1:0] den_reg [QW+1];
    logic [QW:0]     quo_reg [QW+1];

    for (genvar k = 0; k <= QW; k++) begin : g_stage
        logic [NW-1:0]   rin;
        logic [DENW-1:0] din;
        logic [QW:0]     qin;
        logic [CW-1:0]   trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign rin = num;
            assign din = den;
            assign qin = '0;
        end else begin : g_next
            assign rin = rem_reg[k-1];
            assign din = den_reg[k-1];
            assign qin = quo_reg[k-1];
        end

        assign trial = CW'(din) << (QW - k);
        assign ge    = CW'(rin) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? NW'(CW'(rin) - trial) : rin;
                den_reg[k] <= din;
                quo_reg[k] <= qin | ((QW+1)'(ge) << (QW - k));
            end
        end
    end

    // once the top bit is set the remaining bits mean nothing
    assign q = quo_reg[QW][QW] ? {1'b1, {QW{1'b0}}} : quo_reg[QW];

endmodule

@@ rtl/elastic_collision_response_2d.sv @@
`timescale 1ns / 1ps
// Throughput: one word per cycle; set by the pipelined divider, one quotient bit per stage.
// A low m_tready while a result waits freezes the whole pipeline; nothing is lost.
// Reset (aresetn, synchronous, active low) clears the valid bits only and holds
// s_tready low; no state otherwise.
// ----------------------------------------------------------------------------
// elastic_collision_response_2d: velocities of two discs after an elastic impact
// Fixed-point, exact ratio with one truncating division per component.
// ----------------------------------------------------------------------------
module elastic_collision_response_2d
    import ecr_pkg::*;
#(
    parameter int DATA_WIDTH = ECR_DATA_WIDTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // s_tdata from bit 0: pos_a_x, pos_a_y, pos_b_x, pos_b_y,
    //   vel_a_x, vel_a_y, vel_b_x, vel_b_y, mass_a, mass_b, zero pad
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((10*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
    // m_tdata from bit 0: new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y, zero pad
    // m_tuser from bit 0: status[1:0], saturated
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]      m_tdata,
    output logic [2:0]                             m_tuser
);

    localparam int DW    = DATA_WIDTH;
    localparam int OUT_W = ((4*DW+7)/8)*8;
    localparam int MW    = DW + 1;          // magnitudes of differences, mass sum
    localparam int PW    = 2*MW;            // first products, dot, d.d
    localparam int DENW  = MW + PW;         // denominator and 2*m*|dot|
    localparam int NW    = DENW + MW;       // full numerator
    localparam int QW    = DW + 1;          // quotient bits below the overflow bit
    localparam int RW    = DW + 3;          // v +/- q before clamping
    localparam int L     = QW + 8;          // first stage to output register input

    // the whole pipe moves together; it only holds when the output word waits
    logic adv;
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    // no word is taken while in reset
    assign s_tready = adv && aresetn;

    // ---------------- stage 1: differences and mass sum ----------------
    logic signed [DW-1:0] pax, pay, pbx, pby, vax, vay, vbx, vby;
    logic [DW-1:0] ma, mb;
    logic signed [DW:0] dx, dy, dvx, dvy;
    logic [MW-1:0] mt;

    assign pax = $signed(s_tdata[0*DW +: DW]);
    assign pay = $signed(s_tdata[1*DW +: DW]);
    assign pbx = $signed(s_tdata[2*DW +: DW]);
    assign pby = $signed(s_tdata[3*DW +: DW]);
    assign vax = $signed(s_tdata[4*DW +: DW]);
    assign vay = $signed(s_tdata[5*DW +: DW]);
    assign vbx = $signed(s_tdata[6*DW +: DW]);
    assign vby = $signed(s_tdata[7*DW +: DW]);
    assign ma  = s_tdata[8*DW +: DW];
    assign mb  = s_tdata[9*DW +: DW];

    assign dx  = $signed({pax[DW-1], pax}) - $signed({pbx[DW-1], pbx});
    assign dy  = $signed({pay[DW-1], pay}) - $signed({pby[DW-1], pby});
    assign dvx = $signed({vax[DW-1], vax}) - $signed({vbx[DW-1], vbx});
    assign dvy = $signed({vay[DW-1], vay}) - $signed({vby[DW-1], vby});
    assign mt  = {1'b0, ma} + {1'b0, mb};

    logic [MW-1:0] dxm_reg, dym_reg, dvxm_reg, dvym_reg, mt_reg;
    logic          sdx_reg, sdy_reg, nx_reg, ny_reg, coin_reg, zm_reg;
    logic [DW-1:0] ma_reg, mb_reg;
    logic [4*DW-1:0] vel_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dxm_reg  <= dx[DW]  ? MW'(-dx)  : MW'(dx);
            dym_reg  <= dy[DW]  ? MW'(-dy)  : MW'(dy);
            dvxm_reg <= dvx[DW] ? MW'(-dvx) : MW'(dvx);
            dvym_reg <= dvy[DW] ? MW'(-dvy) : MW'(dvy);
            sdx_reg  <= dx[DW];
            sdy_reg  <= dy[DW];
            // sign of each term of dv.d
            nx_reg   <= (dx != '0) && (dvx != '0) && (dx[DW] != dvx[DW]);
            ny_reg   <= (dy != '0) && (dvy != '0) && (dy[DW] != dvy[DW]);
            mt_reg   <= mt;
            ma_reg   <= ma;
            mb_reg   <= mb;
            coin_reg <= (dx == '0) && (dy == '0);
            zm_reg   <= (mt == '0);
            vel_reg  <= s_tdata[4*DW +: 4*DW];
        end
    end

    // ---------------- stages 2-3: dv*d and d*d terms ----------------
    logic [PW-1:0] px, py, qx, qy;

    ecr_mul #(.AW(MW), .BW(MW)) u_mul_px (.aclk, .en(adv), .a(dvxm_reg), .b(dxm_reg), .p(px));
    ecr_mul #(.AW(MW), .BW(MW)) u_mul_py (.aclk, .en(adv), .a(dvym_reg), .b(dym_reg), .p(py));
    ecr_mul #(.AW(MW), .BW(MW)) u_mul_qx (.aclk, .en(adv), .a(dxm_reg),  .b(dxm_reg), .p(qx));
    ecr_mul #(.AW(MW), .BW(MW)) u_mul_qy (.aclk, .en(adv), .a(dym_reg),  .b(dym_reg), .p(qy));

    localparam int AW_D = 2 + 2*MW + MW + 2*DW;
    logic [AW_D-1:0] dla_in, dla_out;
    assign dla_in = {nx_reg, ny_reg, dxm_reg, dym_reg, mt_reg, ma_reg, mb_reg};

    ecr_delay #(.WIDTH(AW_D), .DEPTH(2)) u_dly_a (.aclk, .en(adv), .d(dla_in), .q(dla_out));

    logic          nx_d, ny_d;
    logic [MW-1:0] dxm_d, dym_d, mt_d;
    logic [DW-1:0] ma_d, mb_d;
    assign {nx_d, ny_d, dxm_d, dym_d, mt_d, ma_d, mb_d} = dla_out;

    // ---------------- stage 4: signed dot and d.d ----------------
    logic signed [PW+1:0] sx, sy, dot;
    assign sx  = nx_d ? -$signed({2'b00, px}) : $signed({2'b00, px});
    assign sy  = ny_d ? -$signed({2'b00, py}) : $signed({2'b00, py});
    assign dot = sx + sy;

    logic [PW-1:0] dotm_reg, dd_reg;
    logic          dneg_reg;
    logic [MW-1:0] mt4_reg, dxm4_reg, dym4_reg;
    logic [MW-1:0] ma2_reg, mb2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dotm_reg <= dot[PW+1] ? PW'(-dot) : PW'(dot);
            dneg_reg <= dot[PW+1];
            dd_reg   <= qx + qy;
            mt4_reg  <= mt_d;
            dxm4_reg <= dxm_d;
            dym4_reg <= dym_d;
            ma2_reg  <= {ma_d, 1'b0};
            mb2_reg  <= {mb_d, 1'b0};
        end
    end

    // ---------------- stages 5-6: denominator, 2*m*|dot| ----------------
    logic [DENW-1:0] den, na, nb;

    ecr_mul #(.AW(MW), .BW(PW)) u_mul_den (.aclk, .en(adv), .a(mt4_reg), .b(dd_reg),   .p(den));
    ecr_mul #(.AW(MW), .BW(PW)) u_mul_na  (.aclk, .en(adv), .a(mb2_reg), .b(dotm_reg), .p(na));
    ecr_mul #(.AW(MW), .BW(PW)) u_mul_nb  (.aclk, .en(adv), .a(ma2_reg), .b(dotm_reg), .p(nb));

    logic [2*MW-1:0] dlb_out;
    logic [MW-1:0]   dxm6, dym6;
    ecr_delay #(.WIDTH(2*MW), .DEPTH(2)) u_dly_b (
        .aclk, .en(adv), .d({dxm4_reg, dym4_reg}), .q(dlb_out)
    );
    assign {dxm6, dym6} = dlb_out;

    // ---------------- stages 7-8: full numerators ----------------
    logic [NW-1:0] num_ax, num_ay, num_bx, num_by;

    ecr_mul #(.AW(MW), .BW(DENW)) u_mul_ax (.aclk, .en(adv), .a(dxm6), .b(na), .p(num_ax));
    ecr_mul #(.AW(MW), .BW(DENW)) u_mul_ay (.aclk, .en(adv), .a(dym6), .b(na), .p(num_ay));
    ecr_mul #(.AW(MW), .BW(DENW)) u_mul_bx (.aclk, .en(adv), .a(dxm6), .b(nb), .p(num_bx));
    ecr_mul #(.AW(MW), .BW(DENW)) u_mul_by (.aclk, .en(adv), .a(dym6), .b(nb), .p(num_by));

    logic [DENW-1:0] den8;
    ecr_delay #(.WIDTH(DENW), .DEPTH(2)) u_dly_den (.aclk, .en(adv), .d(den), .q(den8));

    // ---------------- divider stages: QW + 1 ----------------
    logic [QW:0] q_ax, q_ay, q_bx, q_by;

    ecr_div #(.NW(NW), .DENW(DENW), .QW(QW)) u_div_ax (
        .aclk, .en(adv), .num(num_ax), .den(den8), .q(q_ax));
    ecr_div #(.NW(NW), .DENW(DENW), .QW(QW)) u_div_ay (
        .aclk, .en(adv), .num(num_ay), .den(den8), .q(q_ay));
    ecr_div #(.NW(NW), .DENW(DENW), .QW(QW)) u_div_bx (
        .aclk, .en(adv), .num(num_bx), .den(den8), .q(q_bx));
    ecr_div #(.NW(NW), .DENW(DENW), .QW(QW)) u_div_by (
        .aclk, .en(adv), .num(num_by), .den(den8), .q(q_by));

    // ---------------- side band to the output ----------------
    localparam int SE_W = 4*DW + 4;
    logic [SE_W-1:0] dle_out;
    logic [4*DW-1:0] vel_f;
    logic            coin_f, zm_f, sdx_f, sdy_f, dneg_f;

    ecr_delay #(.WIDTH(SE_W), .DEPTH(L)) u_dly_e (
        .aclk, .en(adv), .d({vel_reg, coin_reg, zm_reg, sdx_reg, sdy_reg}), .q(dle_out)
    );
    assign {vel_f, coin_f, zm_f, sdx_f, sdy_f} = dle_out;

    ecr_delay #(.WIDTH(1), .DEPTH(QW+5)) u_dly_dneg (
        .aclk, .en(adv), .d(dneg_reg), .q(dneg_f)
    );

    // valid bits ride along with the data
    logic [L:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[L-1:0], s_tvalid};
        end
    end

    // ---------------- final: apply, clamp, select ----------------
    localparam logic signed [RW-1:0] R_HI = {{(RW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [RW-1:0] R_LO = {{(RW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    // returns {clamped, value}
    function automatic logic [DW:0] apply_fn(input logic [DW-1:0] v,
                                              input logic [QW:0]   q,
                                              input logic          neg);
        logic signed [RW-1:0] ve;
        logic signed [RW-1:0] qe;
        logic signed [RW-1:0] r;
        logic [DW:0]          res;
        ve = $signed({{(RW-DW){v[DW-1]}}, v});
        qe = $signed({1'b0, q});
        r  = neg ? ve + qe : ve - qe;
        if (r > R_HI) begin
            res = {1'b1, R_HI[DW-1:0]};
        end else if (r < R_LO) begin
            res = {1'b1, R_LO[DW-1:0]};
        end else begin
            res = {1'b0, r[DW-1:0]};
        end
        return res;
    endfunction

    logic [DW:0] r_ax, r_ay, r_bx, r_by;
    assign r_ax = apply_fn(vel_f[0*DW +: DW], q_ax, sdx_f ^ dneg_f);
    assign r_ay = apply_fn(vel_f[1*DW +: DW], q_ay, sdy_f ^ dneg_f);
    assign r_bx = apply_fn(vel_f[2*DW +: DW], q_bx, sdx_f ^ !dneg_f);
    assign r_by = apply_fn(vel_f[3*DW +: DW], q_by, sdy_f ^ !dneg_f);

    logic [4*DW-1:0] vel_next;
    logic [1:0]      status_next;
    logic            sat_next;

    always_comb begin
        if (coin_f) begin
            vel_next    = vel_f;
            status_next = ST_COINCIDENT;
            sat_next    = 1'b0;
        end else if (zm_f) begin
            vel_next    = vel_f;
            status_next = ST_ZERO_MASS;
            sat_next    = 1'b0;
        end else begin
            vel_next    = {r_by[DW-1:0], r_bx[DW-1:0], r_ay[DW-1:0], r_ax[DW-1:0]};
            status_next = ST_OK;
            sat_next    = r_ax[DW] | r_ay[DW] | r_bx[DW] | r_by[DW];
        end
    end

    // output register: the word waits here until taken
    logic [4*DW-1:0] vel_out_reg;
    logic [2:0]      user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vld_reg[L];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vel_out_reg <= vel_next;
            user_reg    <= {sat_next, status_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'(vel_out_reg);
    assign m_tuser  = user_reg;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for elastic_collision_response_2d
// Sends directed and random disc pairs with random idle on both sides and
// checks every result word against an exact wide-integer prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import ecr_pkg::*;

    localparam int W         = ECR_DATA_WIDTH;
    localparam int SW        = ((10*W+7)/8)*8;
    localparam int MW        = ((4*W+7)/8)*8;
    localparam int N_RANDOM  = 1600;
    localparam int MAX_CYCLE = 600000;
    localparam int DRAIN     = 2*W + 40;  // comfortably over the pipeline latency

    typedef struct packed {
        logic [W-1:0] vax, vay, vbx, vby;
        ecr_status_t  status;
        logic         sat;
    } impact_t;

    // ------------------------------------------------------------------------
    // Scoreboard: works out post-impact velocities and checks result words
    // ------------------------------------------------------------------------
    class impact_scoreboard;
        impact_t pending[$];
        int      mismatches = 0;
        int      n_checked  = 0;
        int      n_coinc    = 0;
        int      n_nomass   = 0;
        int      n_sat      = 0;

        // v - trunc(2*m*dot*dc / den), clamped to the signed word range
        function automatic logic [W-1:0] new_component(longint v, logic signed [255:0] dot,
                                                      longint dc, logic [255:0] m,
                                                      logic [255:0] den, ref logic sat);
            logic [255:0]         num, quo, mag_dot, mag_dc;
            logic signed [127:0]  r;
            logic signed [127:0]  hi, lo;
            hi      = (128'sd1 <<< (W-1)) - 1;
            lo      = -hi - 1;
            mag_dot = dot < 0 ? -dot : dot;
            mag_dc  = dc < 0 ? -dc : dc;
            num     = 2 * m * mag_dot * mag_dc;
            quo     = num / den;
            if (quo > (256'd1 << 62))
                quo = 256'd1 << 62;
            if ((dot < 0) != (dc < 0))
                r = v + $signed({1'b0, quo[126:0]});
            else
                r = v - $signed({1'b0, quo[126:0]});
            if (r > hi) begin
                r = hi; sat = 1'b1;
            end
            if (r < lo) begin
                r = lo; sat = 1'b1;
            end
            return r[W-1:0];
        endfunction

        function automatic impact_t predict_impact(logic [SW-1:0] w);
            impact_t             e;
            longint              pax, pay, pbx, pby, vax, vay, vbx, vby, dx, dy;
            logic [255:0]        ma, mb, mt, dd, den;
            logic signed [255:0] dot, sdx, sdy, sdvx, sdvy;
            logic                sat;
            pax = $signed(w[0*W +: W]);  pay = $signed(w[1*W +: W]);
            pbx = $signed(w[2*W +: W]);  pby = $signed(w[3*W +: W]);
            vax = $signed(w[4*W +: W]);  vay = $signed(w[5*W +: W]);
            vbx = $signed(w[6*W +: W]);  vby = $signed(w[7*W +: W]);
            ma  = w[8*W +: W];           mb  = w[9*W +: W];
            mt  = ma + mb;
            dx  = pax - pbx;             dy  = pay - pby;
            e.vax = vax[W-1:0]; e.vay = vay[W-1:0];
            e.vbx = vbx[W-1:0]; e.vby = vby[W-1:0];
            e.sat = 1'b0;
            if (dx == 0 && dy == 0) begin
                e.status = ST_COINCIDENT;
                return e;
            end
            if (mt == 0) begin
                e.status = ST_ZERO_MASS;
                return e;
            end
            sdx  = dx;         sdy  = dy;
            sdvx = vax - vbx;  sdvy = vay - vby;
            dot  = sdvx * sdx + sdvy * sdy;
            dd   = sdx * sdx + sdy * sdy;
            den  = mt * dd;
            sat  = 1'b0;
            e.vax = new_component(vax, dot, dx, mb, den, sat);
            e.vay = new_component(vay, dot, dy, mb, den, sat);
            e.vbx = new_component(vbx, -dot, dx, ma, den, sat);
            e.vby = new_component(vby, -dot, dy, ma, den, sat);
            e.status = ST_OK;
            e.sat    = sat;
            return e;
        endfunction

        function void note_pair(logic [SW-1:0] w);
            pending.push_back(predict_impact(w));
        endfunction

        function void check_result(logic [MW-1:0] d, logic [2:0] u);
            impact_t e, a;
            a.vax = d[0*W +: W]; a.vay = d[1*W +: W];
            a.vbx = d[2*W +: W]; a.vby = d[3*W +: W];
            a.status = ecr_status_t'(u[1:0]);
            a.sat    = u[2];
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word %h / %h", d, u);
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (e.status == ST_COINCIDENT) n_coinc++;
            if (e.status == ST_ZERO_MASS)  n_nomass++;
            if (e.sat)                     n_sat++;
            if (a !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: word %0d vax %h/%h vay %h/%h vbx %h/%h vby %h/%h st %0d/%0d sat %0b/%0b (exp/act)",
                             n_checked, e.vax, a.vax, e.vay, a.vay, e.vbx, a.vbx,
                             e.vby, a.vby, e.status, a.status, e.sat, a.sat);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [MW-1:0] m_tdata;   // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
    logic [2:0]    m_tuser;   // status[1:0], saturated

    impact_scoreboard sb = new();
    int  cycles = 0;
    int  n_results = 0;
    bit  sending_done = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    elastic_collision_response_2d dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // monitors: both sample handshakes at the edge, before any NBA lands
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && s_tvalid && s_tready)
            sb.note_pair(s_tdata);
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
            n_results <= n_results + 1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycles > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycles);
            $display("elastic_collision_response_2d verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // one field value, mixing full range, small magnitudes and extremes
    function automatic logic [W-1:0] pick_field(bit is_mass);
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: begin
                return $urandom;
            end
            3: begin
                return is_mass ? '0 : {1'b1, {(W-1){1'b0}}};
            end
            4: begin
                return {1'b0, {(W-1){1'b1}}};
            end
            default: begin
                // moderate magnitudes keep most results in range
                logic [W-1:0] v;
                v = $urandom_range(0, 1 << 22);
                if (!is_mass && $urandom_range(0, 1))
                    v = -v;
                return v;
            end
        endcase
    endfunction

    function automatic logic [SW-1:0] random_pair();
        logic [SW-1:0] w;
        w = '0;
        for (int i = 0; i < 10; i++)
            w[i*W +: W] = pick_field(i >= 8);
        // now and then force the special cases
        case ($urandom_range(0, 19))
            0: w[2*W +: 2*W] = w[0 +: 2*W];                 // same centre
            1: begin
                w[8*W +: 2*W] = '0;                         // massless pair
            end
            2: begin
                w[2*W +: 2*W] = w[0 +: 2*W];
                w[8*W +: 2*W] = '0;
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [SW-1:0] make_pair(longint pax, longint pay, longint pbx,
                                                longint pby, longint vax, longint vay,
                                                longint vbx, longint vby,
                                                longint ma, longint mb);
        return {mb[W-1:0], ma[W-1:0], vby[W-1:0], vbx[W-1:0], vay[W-1:0], vax[W-1:0],
                pby[W-1:0], pbx[W-1:0], pay[W-1:0], pax[W-1:0]};
    endfunction

    task automatic send_pair(logic [SW-1:0] w, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
    endtask

    localparam longint ONE  = 64'h1_0000;
    localparam longint MAXV = 64'h7FFF_FFFF;
    localparam longint MINV = -64'h8000_0000;
    localparam longint MAXM = 64'hFFFF_FFFF;

    initial begin
        logic [SW-1:0] dir[$];
        int gap;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // head-on, equal masses: velocities swap
        dir.push_back(make_pair(ONE, 0, 0, 0, -ONE, 0, ONE, 0, ONE, ONE));
        // glancing, unequal masses
        dir.push_back(make_pair(3*ONE, 4*ONE, 0, 0, -ONE, 2*ONE, ONE/2, -ONE, 2*ONE, ONE));
        // same centres, and same centres with no mass
        dir.push_back(make_pair(5, -7, 5, -7, ONE, ONE, -ONE, 3, ONE, ONE));
        dir.push_back(make_pair(MINV, MAXV, MINV, MAXV, MAXV, MINV, 1, -1, 0, 0));
        // zero total mass
        dir.push_back(make_pair(ONE, ONE, 0, 0, 9, 8, 7, 6, 0, 0));
        // one massless disc bounces off
        dir.push_back(make_pair(ONE, 0, 0, 0, -ONE, 0, 0, 0, 0, ONE));
        // tangential: dot product of zero along the normal
        dir.push_back(make_pair(0, ONE, 0, 0, ONE, 0, -ONE, 0, ONE, ONE));
        // extreme centres or velocities and the heaviest masses: saturation
        dir.push_back(make_pair(MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXM, MAXM));
        dir.push_back(make_pair(MINV, 0, MAXV, 0, MAXV, MAXV, MINV, MINV, MAXM, 1));
        dir.push_back(make_pair(1, 0, 0, 0, MAXV, 0, MINV, 0, 1, MAXM));
        // all bits set, and nearly all clear
        dir.push_back({SW{1'b1}});
        dir.push_back(make_pair(0, 1, 0, 0, 0, 0, 0, 0, 0, 1));
        dir.push_back(make_pair(-1, -1, 0, 0, -1, -1, 0, 0, MAXM, MAXM));
        dir.push_back(make_pair(MAXV, 0, MAXV - 1, 0, 0, MINV, 0, MAXV, 1, 1));
        foreach (dir[i])
            send_pair(dir[i], $urandom_range(0, 8));

        for (int i = 0; i < N_RANDOM; i++) begin
            // every third block of 200 runs back to back
            gap = ((i / 200) % 3 == 1) ? 0 : $urandom_range(0, 8);
            send_pair(random_pair(), gap);
        end
        s_tvalid     <= 1'b0;
        sending_done  = 1'b1;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, one long hold-off to back the pipe up
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        int k;
        k = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (k == 300) begin
                // long hold-off while the sender keeps offering words
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            stall = ((k / 250) % 3 == 2) ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            k++;
        end
    end

    // ------------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------------
    initial begin
        wait (sending_done);
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        $display("checked %0d result words: %0d same-centre, %0d massless, %0d saturated",
                 sb.n_checked, sb.n_coinc, sb.n_nomass, sb.n_sat);
        $display("mismatches %0d, run took %0d cycles", sb.mismatches, cycles);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("elastic_collision_response_2d verification clean");
        else
            $display("elastic_collision_response_2d verification failed");
        $finish;
    end

endmodule

@@ elastic_collision_response_2d.f @@
rtl/ecr_pkg.sv
rtl/ecr_delay.sv
rtl/ecr_mul.sv
rtl/ecr_div.sv
rtl/elastic_collision_response_2d.sv
tb/tb_top.sv
